/* rtl/md4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 digest package
// Types, constants and step tables shared by the MD4 digest modules.
// ----------------------------------------------------------------------------
package md4_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_CRD,
    S_RUN,
    S_ADD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] rnd;
    logic [4:0] rot;
  } step_ctrl_t;

  localparam int unsigned NumSteps = 48;

  localparam logic [31:0] IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  function automatic logic [3:0] word_index(input logic [5:0] s);
    logic [3:0] t;
    logic [3:0] r;
    t = s[3:0];
    r = t;
    unique case (s[5:4])
      2'd0:    r = t;
      2'd1:    r = {t[1:0], t[3:2]};
      2'd2:    r = {t[0], t[1], t[2], t[3]};
      default: r = t;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [1:0] rnd, input logic [1:0] j);
    logic [4:0] r;
    r = 5'd3;
    unique case (rnd)
      2'd0: begin
        unique case (j)
          2'd0: r = 5'd3;
          2'd1: r = 5'd7;
          2'd2: r = 5'd11;
          default: r = 5'd19;
        endcase
      end
      2'd1: begin
        unique case (j)
          2'd0: r = 5'd3;
          2'd1: r = 5'd5;
          2'd2: r = 5'd9;
          default: r = 5'd13;
        endcase
      end
      default: begin
        unique case (j)
          2'd0: r = 5'd3;
          2'd1: r = 5'd9;
          2'd2: r = 5'd11;
          default: r = 5'd15;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_const(input logic [1:0] rnd);
    logic [31:0] k;
    unique case (rnd)
      2'd0:    k = 32'h00000000;
      2'd1:    k = 32'h5a827999;
      default: k = 32'h6ed9eba1;
    endcase
    return k;
  endfunction

endpackage

/* rtl/md4_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 byte channel
// Valid/ready channel carrying one message byte item with its flags.
// ----------------------------------------------------------------------------
interface md4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

/* rtl/md4_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 digest channel
// Valid/ready channel carrying one digest word item.
// ----------------------------------------------------------------------------
interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        word_last;

  modport source (output valid, digest_word, word_last, input ready);
  modport sink   (input valid, digest_word, word_last, output ready);
endinterface

/* rtl/md4_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 step unit
// One compression step: round function, add of word and constant, rotate.
// ----------------------------------------------------------------------------
module md4_step (
  input  md4_pkg::step_ctrl_t ctrl,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  input  logic [31:0]         c,
  input  logic [31:0]         d,
  input  logic [31:0]         w,
  output logic [31:0]         result
);
  import md4_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot64;

  always_comb begin
    unique case (ctrl.rnd)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
  end

  assign sum    = a + f + w + round_const(ctrl.rnd);
  assign rot64  = {sum, sum} << ctrl.rot;
  assign result = rot64[63:32];

endmodule

/* rtl/md4_message_digest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 message digest
// Byte-streamed MD4 hash with a 16-word block memory and iterative compression.
//
//   channel     dir  handshake     payload
//   byte_ch     in   valid/ready   data_byte, byte_valid, last_byte
//   digest_ch   out  valid/ready   digest_word, word_last
//
// Byte items are taken while idle. The item that fills the block stalls input
// for one memory read set-up, 48 steps through the shared step unit and one
// chaining add. A last item brings pad writes from its word up to word 15, and
// a compression per padded block (one or two; a second one is padded whole),
// plus one more when its byte fills the block, then four digest items, held
// until taken. Reset is synchronous; the block memory is not cleared.
// ----------------------------------------------------------------------------
module md4_message_digest (
  input  logic      clk,
  input  logic      rst,
  md4_in_if.sink    byte_ch,
  md4_out_if.source digest_ch
);
  import md4_pkg::*;

  state_t      state, state_next;
  logic [5:0]  buffered_bytes;
  logic [60:0] msg_bytes;
  logic [31:0] acc;
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [5:0]  step;
  logic [3:0]  wi;
  logic        fin;
  logic        phase;
  logic        pad_blk;
  logic [1:0]  k;

  logic [31:0] blk_mem [16];
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata;

  logic        in_acc, out_acc;
  logic [5:0]  pos_next;
  logic [31:0] acc_next;
  logic        blk_full;
  logic        long_pad;
  logic [63:0] bit_len;
  logic [31:0] pad_word;
  logic [5:0]  step_inc;
  step_ctrl_t  ctrl;
  logic [31:0] step_out;

  assign in_acc   = byte_ch.valid && byte_ch.ready;
  assign out_acc  = digest_ch.valid && digest_ch.ready;
  assign pos_next = buffered_bytes + {5'd0, byte_ch.byte_valid};
  assign acc_next = (buffered_bytes[1:0] == 2'd0) ? {24'd0, byte_ch.data_byte} :
                    (acc | ({24'd0, byte_ch.data_byte} << {buffered_bytes[1:0], 3'b000}));
  assign blk_full = in_acc && byte_ch.byte_valid && (buffered_bytes == 6'd63);
  assign long_pad = buffered_bytes > 6'd55;
  assign bit_len  = {msg_bytes + {55'd0, buffered_bytes}, 3'b000};
  assign step_inc = step + 6'd1;

  always_comb begin
    if (!phase && (wi == buffered_bytes[5:2])) begin
      pad_word = ((buffered_bytes[1:0] == 2'd0) ? 32'd0 : acc) |
                 (32'h80 << {buffered_bytes[1:0], 3'b000});
    end else if ((wi == 4'd14) && (phase || !long_pad)) begin
      pad_word = bit_len[31:0];
    end else if ((wi == 4'd15) && (phase || !long_pad)) begin
      pad_word = bit_len[63:32];
    end else begin
      pad_word = 32'd0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (blk_full) begin
            state_next = S_CRD;
          end else if (byte_ch.last_byte) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (wi == 4'd15) begin
          state_next = S_CRD;
        end
      end
      S_CRD: state_next = S_RUN;
      S_RUN: begin
        if (step == 6'(NumSteps - 1)) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (!pad_blk) begin
          state_next = fin ? S_PAD : S_IDLE;
        end else if (!phase && long_pad) begin
          state_next = S_PAD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc && (k == 2'd3)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    byte_ch.ready         = 1'b0;
    digest_ch.valid       = 1'b0;
    digest_ch.digest_word = chain[k];
    digest_ch.word_last   = (k == 2'd3);
    mem_we                = 1'b0;
    mem_waddr             = buffered_bytes[5:2];
    mem_wdata             = acc_next;
    mem_raddr             = word_index(step_inc);
    unique case (state)
      S_IDLE: begin
        byte_ch.ready = 1'b1;
        mem_we        = in_acc && byte_ch.byte_valid && (buffered_bytes[1:0] == 2'd3);
      end
      S_PAD: begin
        mem_we    = 1'b1;
        mem_waddr = wi;
        mem_wdata = pad_word;
      end
      S_CRD: mem_raddr = word_index(6'd0);
      S_RUN: mem_raddr = word_index(step_inc);
      S_ADD: ;
      S_OUT: digest_ch.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= blk_mem[mem_raddr];
  end

  assign ctrl.rnd = step[5:4];
  assign ctrl.rot = rot_amount(step[5:4], step[1:0]);

  md4_step u_step (
    .ctrl   (ctrl),
    .a      (a),
    .b      (b),
    .c      (c),
    .d      (d),
    .w      (mem_rdata),
    .result (step_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      buffered_bytes <= '0;
      msg_bytes      <= '0;
      fin            <= 1'b0;
      phase          <= 1'b0;
      pad_blk        <= 1'b0;
      k              <= '0;
      step           <= '0;
      wi             <= '0;
      for (int i = 0; i < 4; i++) chain[i] <= IV[i];
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          pad_blk <= 1'b0;
          if (in_acc) begin
            if (byte_ch.byte_valid) begin
              acc            <= acc_next;
              buffered_bytes <= pos_next;
            end
            if (byte_ch.last_byte) begin
              fin <= 1'b1;
            end
            wi <= pos_next[5:2];
          end
        end
        S_PAD: begin
          wi <= wi + 4'd1;
          if (wi == 4'd15) begin
            pad_blk <= 1'b1;
          end
        end
        S_CRD: begin
          a    <= chain[0];
          b    <= chain[1];
          c    <= chain[2];
          d    <= chain[3];
          step <= '0;
        end
        S_RUN: begin
          a    <= d;
          b    <= step_out;
          c    <= b;
          d    <= c;
          step <= step_inc;
        end
        S_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          wi       <= '0;
          if (!pad_blk) begin
            msg_bytes <= msg_bytes + 61'd64;
          end else if (!phase && long_pad) begin
            phase <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            k <= k + 2'd1;
            if (k == 2'd3) begin
              buffered_bytes <= '0;
              msg_bytes      <= '0;
              fin            <= 1'b0;
              phase          <= 1'b0;
              for (int i = 0; i < 4; i++) chain[i] <= IV[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(byte_ch.ready && digest_ch.valid))
    else $error("byte input open while digest pending");

  a_clear_after_digest: assert property (@(posedge clk) disable iff (rst)
    out_acc && digest_ch.word_last |=> (buffered_bytes == 6'd0) && (msg_bytes == 61'd0)
                                       && (chain[0] == IV[0]) && !fin)
    else $error("message state not cleared after digest");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (step < 6'(NumSteps)))
    else $error("step counter out of range");

  a_no_write_in_compress: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !((state == S_RUN) || (state == S_CRD) || (state == S_ADD)))
    else $error("block memory written during compression");

  a_run_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_CRD) |=> (state == S_RUN) && (step == 6'd0))
    else $error("compression did not start at step zero");

endmodule
